>>> hw/rtl/pmcc_pkg.sv
// Shared widths, constants, register indexes and types for the pot median scaler.
package pmcc_pkg;

    localparam int OVERSAMPLE = 5;
    localparam int MED_IDX    = OVERSAMPLE / 2;
    localparam int NUM_POTS   = 3;

    localparam int SAMPLE_W = 12;
    localparam int CNT_W    = 3;
    localparam int CH_W     = 2;
    localparam int MIDI_W   = 7;
    localparam int IDX_W    = 3;
    localparam int NUM_W    = SAMPLE_W + MIDI_W;

    localparam logic [MIDI_W-1:0] MIDI_MAX = 7'd127;

    typedef enum logic [IDX_W-1:0] {
        REG_LOW_THR  = 3'd0,
        REG_HIGH_THR = 3'd1,
        REG_STEP     = 3'd2,
        REG_CC_ZERO  = 3'd3,
        REG_CC_ONE   = 3'd4,
        REG_CC_TWO   = 3'd5
    } t_reg_idx;

    localparam logic [CH_W-1:0] CH_ZERO = 2'd0;
    localparam logic [CH_W-1:0] CH_ONE  = 2'd1;
    localparam logic [CH_W-1:0] CH_NONE = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MAP  = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    // Divider handshake toward the top level
    typedef struct packed {
        logic done;
    } t_div_status;

endpackage

>>> hw/rtl/pot_median_to_cc_scaler.sv
// Top level: median of OVERSAMPLE samples per pot, threshold scaling, deadband, CC output.
//
// Samples for pots 0..2 enter one per cycle while the input is not stalled; a sample
// tagged 3 is dropped. Each accepted sample is inserted into a row of five sorting
// cells in the cycle it arrives. The item that closes a group holds the input stalled
// through a map state and an emit state when the median clamps to 0 or 127, and
// also through the 7-step restoring divider that computes (x-low)*127/(high-low)
// otherwise; the emit state also waits while a pending result sits on a stalled
// output register. A sample from another pot drops a partly collected group. The
// first completed group of each pot only sets its stored value; later groups give a
// result when the value moved by at least the change step. Configuration writes take
// effect at once; they are to be made while idle, which the block does not enforce.
module pot_median_to_cc_scaler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pmcc_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [pmcc_pkg::SAMPLE_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pmcc_pkg::CH_W-1:0]     i_pot_channel,
    input  logic [pmcc_pkg::SAMPLE_W-1:0] i_adc_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pmcc_pkg::CH_W-1:0]     o_out_channel,
    output logic [pmcc_pkg::MIDI_W-1:0]   o_control_number,
    output logic [pmcc_pkg::MIDI_W-1:0]   o_control_value
);

    localparam int N = pmcc_pkg::OVERSAMPLE;

    // configuration
    logic [pmcc_pkg::SAMPLE_W-1:0] r_low_thr;
    logic [pmcc_pkg::SAMPLE_W-1:0] r_high_thr;
    logic [pmcc_pkg::MIDI_W-1:0]   r_step;
    logic [pmcc_pkg::MIDI_W-1:0]   r_cc_zero;
    logic [pmcc_pkg::MIDI_W-1:0]   r_cc_one;
    logic [pmcc_pkg::MIDI_W-1:0]   r_cc_two;

    // control
    pmcc_pkg::t_state              r_state, n_state;
    logic [pmcc_pkg::CNT_W-1:0]    r_count, n_count;
    logic [pmcc_pkg::CH_W-1:0]     r_group_ch, n_group_ch;
    logic [pmcc_pkg::NUM_POTS-1:0] r_primed, n_primed;
    logic [pmcc_pkg::MIDI_W-1:0]   r_last [pmcc_pkg::NUM_POTS];
    logic                          r_out_valid, n_out_valid;

    // payload
    logic [pmcc_pkg::MIDI_W-1:0]   r_map;
    logic [pmcc_pkg::CH_W-1:0]     r_out_ch;
    logic [pmcc_pkg::MIDI_W-1:0]   r_out_num;
    logic [pmcc_pkg::MIDI_W-1:0]   r_out_val;

    logic                          in_acc;
    logic                          take;
    logic [pmcc_pkg::CNT_W-1:0]    count_eff;
    logic [pmcc_pkg::CNT_W-1:0]    count_inc;
    logic [pmcc_pkg::SAMPLE_W-1:0] cell_val [N];
    logic                          cell_le  [N];
    logic [pmcc_pkg::SAMPLE_W-1:0] median;
    logic [pmcc_pkg::SAMPLE_W-1:0] span_x;
    logic [pmcc_pkg::NUM_W-1:0]    div_num;
    logic [pmcc_pkg::SAMPLE_W-1:0] div_den;
    logic                          div_start;
    pmcc_pkg::t_div_status         div_status;
    logic [pmcc_pkg::MIDI_W-1:0]   div_quot;
    logic [pmcc_pkg::MIDI_W-1:0]   last_sel;
    logic [pmcc_pkg::MIDI_W-1:0]   delta;
    logic [pmcc_pkg::MIDI_W-1:0]   cc_sel;
    logic                          out_free;
    logic                          emit_go;

    assign o_in_stall = (r_state != pmcc_pkg::S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign take       = in_acc && (i_pot_channel != pmcc_pkg::CH_NONE);

    // Restart the group on a pot switch.
    assign count_eff = ((r_count != '0) && (i_pot_channel != r_group_ch)) ? '0 : r_count;
    assign count_inc = count_eff + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr  <= 12'd0;
            r_high_thr <= 12'd4095;
            r_step     <= 7'd3;
            r_cc_zero  <= 7'd7;
            r_cc_one   <= 7'd74;
            r_cc_two   <= 7'd71;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pmcc_pkg::REG_LOW_THR:  r_low_thr  <= i_cfg_data;
                pmcc_pkg::REG_HIGH_THR: r_high_thr <= i_cfg_data;
                pmcc_pkg::REG_STEP:     r_step     <= i_cfg_data[pmcc_pkg::MIDI_W-1:0];
                pmcc_pkg::REG_CC_ZERO:  r_cc_zero  <= i_cfg_data[pmcc_pkg::MIDI_W-1:0];
                pmcc_pkg::REG_CC_ONE:   r_cc_one   <= i_cfg_data[pmcc_pkg::MIDI_W-1:0];
                pmcc_pkg::REG_CC_TWO:   r_cc_two   <= i_cfg_data[pmcc_pkg::MIDI_W-1:0];
                default: ;
            endcase
        end
    end

    // sorting row
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic occ;
            assign occ = (pmcc_pkg::CNT_W'(g) < count_eff);
            if (g == 0) begin : g_first
                pmcc_sort_cell u_cell (
                    .i_clk      (i_clk),
                    .i_insert   (take),
                    .i_occ      (occ),
                    .i_sample   (i_adc_sample),
                    .i_left_val (i_adc_sample),
                    .i_left_le  (1'b1),
                    .o_val      (cell_val[g]),
                    .o_le       (cell_le[g])
                );
            end else begin : g_rest
                pmcc_sort_cell u_cell (
                    .i_clk      (i_clk),
                    .i_insert   (take),
                    .i_occ      (occ),
                    .i_sample   (i_adc_sample),
                    .i_left_val (cell_val[g-1]),
                    .i_left_le  (cell_le[g-1]),
                    .o_val      (cell_val[g]),
                    .o_le       (cell_le[g])
                );
            end
        end
    endgenerate

    assign median  = cell_val[pmcc_pkg::MED_IDX];
    assign span_x  = median - r_low_thr;
    assign div_num = {span_x, {pmcc_pkg::MIDI_W{1'b0}}}
                   - {{pmcc_pkg::MIDI_W{1'b0}}, span_x};
    assign div_den = r_high_thr - r_low_thr;
    assign div_start = (r_state == pmcc_pkg::S_MAP) && (median > r_low_thr)
                     && (median < r_high_thr);

    pmcc_divider u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (div_num),
        .i_den    (div_den),
        .o_status (div_status),
        .o_quot   (div_quot)
    );

    assign last_sel = r_last[r_group_ch];
    assign delta    = (r_map >= last_sel) ? (r_map - last_sel) : (last_sel - r_map);
    assign out_free = !r_out_valid || !i_out_stall;
    assign emit_go  = (r_state == pmcc_pkg::S_EMIT) && r_primed[r_group_ch]
                    && (delta >= r_step) && out_free;

    always_comb begin
        if (r_group_ch == pmcc_pkg::CH_ZERO) begin
            cc_sel = r_cc_zero;
        end else if (r_group_ch == pmcc_pkg::CH_ONE) begin
            cc_sel = r_cc_one;
        end else begin
            cc_sel = r_cc_two;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_group_ch  = r_group_ch;
        n_primed    = r_primed;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            pmcc_pkg::S_IDLE: begin
                if (take) begin
                    n_group_ch = i_pot_channel;
                    if (count_inc == pmcc_pkg::CNT_W'(N)) begin
                        n_count = '0;
                        n_state = pmcc_pkg::S_MAP;
                    end else begin
                        n_count = count_inc;
                    end
                end
            end
            pmcc_pkg::S_MAP: begin
                n_state = div_start ? pmcc_pkg::S_DIV : pmcc_pkg::S_EMIT;
            end
            pmcc_pkg::S_DIV: begin
                if (div_status.done) begin
                    n_state = pmcc_pkg::S_EMIT;
                end
            end
            pmcc_pkg::S_EMIT: begin
                if (!r_primed[r_group_ch]) begin
                    n_primed[r_group_ch] = 1'b1;
                    n_state = pmcc_pkg::S_IDLE;
                end else if (delta < r_step) begin
                    n_state = pmcc_pkg::S_IDLE;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state = pmcc_pkg::S_IDLE;
                end
            end
            default: n_state = pmcc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pmcc_pkg::S_IDLE;
            r_count     <= '0;
            r_group_ch  <= '0;
            r_primed    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_group_ch  <= n_group_ch;
            r_primed    <= n_primed;
            r_out_valid <= n_out_valid;
        end
    end

    // Stored value moves on priming and on every emitted result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < pmcc_pkg::NUM_POTS; k++) begin
                r_last[k] <= '0;
            end
        end else if ((r_state == pmcc_pkg::S_EMIT)
                     && (!r_primed[r_group_ch] || emit_go)) begin
            r_last[r_group_ch] <= r_map;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pmcc_pkg::S_MAP) begin
            r_map <= (median <= r_low_thr) ? '0 : pmcc_pkg::MIDI_MAX;
        end else if ((r_state == pmcc_pkg::S_DIV) && div_status.done) begin
            r_map <= div_quot;
        end
        if (emit_go) begin
            r_out_ch  <= r_group_ch;
            r_out_num <= cc_sel;
            r_out_val <= r_map;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_channel    = r_out_ch;
    assign o_control_number = r_out_num;
    assign o_control_value  = r_out_val;

endmodule

>>> hw/rtl/pmcc_sort_cell.sv
// One cell of the insertion sort row: holds one sample, ascending left to right.
module pmcc_sort_cell (
    input  logic                          i_clk,
    input  logic                          i_insert,
    input  logic                          i_occ,
    input  logic [pmcc_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [pmcc_pkg::SAMPLE_W-1:0] i_left_val,
    input  logic                          i_left_le,
    output logic [pmcc_pkg::SAMPLE_W-1:0] o_val,
    output logic                          o_le
);

    logic [pmcc_pkg::SAMPLE_W-1:0] r_val;
    logic [pmcc_pkg::SAMPLE_W-1:0] n_val;

    assign o_le = i_occ && (r_val <= i_sample);

    // Keep if already at or below the new sample, else take the sample or shift right.
    always_comb begin
        if (o_le) begin
            n_val = r_val;
        end else if (i_left_le) begin
            n_val = i_sample;
        end else begin
            n_val = i_left_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_insert) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule

>>> hw/rtl/pmcc_divider.sv
// Restoring divider, one quotient bit per cycle, for the 7-bit scaled level.
module pmcc_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pmcc_pkg::NUM_W-1:0]    i_num,
    input  logic [pmcc_pkg::SAMPLE_W-1:0] i_den,
    output pmcc_pkg::t_div_status         o_status,
    output logic [pmcc_pkg::MIDI_W-1:0]   o_quot
);

    logic                          r_busy;
    logic [pmcc_pkg::CNT_W-1:0]    r_cnt;
    logic [pmcc_pkg::SAMPLE_W-1:0] r_rem;
    logic [pmcc_pkg::MIDI_W-1:0]   r_shift;
    logic [pmcc_pkg::MIDI_W-1:0]   r_quot;
    logic [pmcc_pkg::SAMPLE_W-1:0] r_den;

    logic [pmcc_pkg::SAMPLE_W:0]   trial;
    logic [pmcc_pkg::SAMPLE_W:0]   diff;
    logic                          ge;

    assign trial = {r_rem, r_shift[pmcc_pkg::MIDI_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= pmcc_pkg::CNT_W'(pmcc_pkg::MIDI_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Quotient is below 128, so the top bits of the numerator start below the divisor.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= i_num[pmcc_pkg::NUM_W-1:pmcc_pkg::MIDI_W];
            r_shift <= i_num[pmcc_pkg::MIDI_W-1:0];
            r_den   <= i_den;
            r_quot  <= '0;
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem   <= ge ? diff[pmcc_pkg::SAMPLE_W-1:0] : trial[pmcc_pkg::SAMPLE_W-1:0];
            r_shift <= {r_shift[pmcc_pkg::MIDI_W-2:0], 1'b0};
            r_quot  <= {r_quot[pmcc_pkg::MIDI_W-2:0], ge};
        end
    end

    assign o_status.done = r_busy && (r_cnt == '0);
    assign o_quot        = r_quot;

endmodule

>>> hw/rtl/pmcc_checker.sv
// Port-level checks for the pot median scaler, bound to the top level.
module pmcc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [pmcc_pkg::CH_W-1:0]     o_out_channel
);

    // A waiting result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // Reset empties the output and frees the input.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear control state");

    // Results only ever name a real pot.
    a_out_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_channel != pmcc_pkg::CH_NONE))
        else $error("result for pot three");

    // A new result follows a cycle in which the block was busy on a group.
    a_out_from_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without group processing");

endmodule

bind pot_median_to_cc_scaler pmcc_checker u_pmcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_channel (o_out_channel)
);
